// File: rtl/samstk_pkg.sv
// ----------------------------------------------------------------------------
// samstk_pkg
// Shared types, codes and defaults for the shared-array multi-stack.
// ----------------------------------------------------------------------------
package samstk_pkg;

	// defaults handed to the top-level parameters
	localparam int MAX_STACKS_DEF  = 16;
	localparam int DEPTH_DEF       = 1024;
	localparam int VALUE_WIDTH_DEF = 32;

	// fixed field widths
	localparam int NUM_W    = 5;
	localparam int SLOTS_W  = 11;
	localparam int CFG_W    = 11;
	localparam int STKNUM_W = 4;
	localparam int DATA_W   = 32;
	localparam int STAT_W   = 2;

	// register reset values
	localparam logic [NUM_W-1:0]   NUM_STACKS_RST   = 5'd16;
	localparam logic [SLOTS_W-1:0] SLOTS_IN_USE_RST = 11'd1024;

	// configuration register indexes
	localparam logic REG_NUM_STACKS = 1'b0;
	localparam logic REG_SLOTS      = 1'b1;

	// request operation
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// result status
	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // request word taken this cycle
		logic finish;    // commit state updates and load the result
		logic in_fetch;  // finishing from the pop fetch step
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pop_go;    // valid pop on a non-empty stack
		logic out_free;  // result register can take a word
	} sts_t;

endpackage

// File: rtl/shared_array_multi_stack_top.sv
// ----------------------------------------------------------------------------
// shared_array_multi_stack_top
// Several LIFO stacks sharing one slot store through a free-slot stack.
// ----------------------------------------------------------------------------
// Each request word pushes a value onto a numbered stack or pops one from it,
// and gives exactly one result word. Requests are handled one at a time. A
// push, or a pop that fails, is loaded into the result register from the
// look-up state (head and free-slot memories are read, then the head and
// slot memories are written). A pop of a non-empty stack is loaded from the
// fetch state that follows, since the slot memory can only be read once the
// head memory has returned the head slot. The result sits in an output
// register, so the next request is accepted at the edge after the result is
// loaded, even while downstream still holds it; a result that cannot be
// loaded because the previous word is still waiting stalls the block for as
// long as that word waits. Writing either configuration register clears all
// stacks and refills the free stack; there is no clearing pass, the free
// stack reads its untouched entries as their own slot numbers. Config writes
// are expected only while the block is idle.
// ----------------------------------------------------------------------------
module shared_array_multi_stack_top #(
	parameter int MAX_STACKS  = samstk_pkg::MAX_STACKS_DEF,
	parameter int DEPTH       = samstk_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH = samstk_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration: index 0 num_stacks, index 1 slots_in_use
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [samstk_pkg::CFG_W-1:0]  cfg_data,
	// request stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [samstk_pkg::DATA_W-1:0] s_tdata,   // push_value[31:0]
	input  logic [samstk_pkg::STKNUM_W:0] s_tuser,   // operation[0], stack_number[4:1]
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [samstk_pkg::DATA_W-1:0] m_tdata,   // pop_value[31:0]
	output logic [samstk_pkg::STAT_W-1:0] m_tuser    // status[1:0]
);

	samstk_pkg::cmd_t cmd;
	samstk_pkg::sts_t sts;

	// sequencer
	samstk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage and result register
	samstk_dp #(
		.MAX_STACKS  (MAX_STACKS),
		.DEPTH       (DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// File: rtl/samstk_ram.sv
// ----------------------------------------------------------------------------
// samstk_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module samstk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/samstk_ctrl.sv
// ----------------------------------------------------------------------------
// samstk_ctrl
// Request sequencer: accept, look up head / free slot, fetch popped slot.
// ----------------------------------------------------------------------------
module samstk_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  samstk_pkg::sts_t   sts,
	output samstk_pkg::cmd_t   cmd
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_LOOK  = 3'b010,
		S_FETCH = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d      = state_q;
		cmd.capture  = 1'b0;
		cmd.finish   = 1'b0;
		cmd.in_fetch = 1'b0;
		s_tready     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
				if (s_tvalid) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				if (sts.pop_go) begin
					state_d = S_FETCH;
				end else if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_FETCH: begin
				cmd.in_fetch = 1'b1;
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/samstk_dp.sv
// ----------------------------------------------------------------------------
// samstk_dp
// Datapath: config registers, head/slot/free-stack memories, result register.
// ----------------------------------------------------------------------------
module samstk_dp #(
	parameter int MAX_STACKS  = samstk_pkg::MAX_STACKS_DEF,
	parameter int DEPTH       = samstk_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH = samstk_pkg::VALUE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [samstk_pkg::CFG_W-1:0]      cfg_data,
	input  logic [samstk_pkg::DATA_W-1:0]     s_tdata,
	input  logic [samstk_pkg::STKNUM_W:0]     s_tuser,
	input  logic                              m_tready,
	output logic                              m_tvalid,
	output logic [samstk_pkg::DATA_W-1:0]     m_tdata,
	output logic [samstk_pkg::STAT_W-1:0]     m_tuser,
	input  samstk_pkg::cmd_t                  cmd,
	output samstk_pkg::sts_t                  sts
);

	localparam int AW  = $clog2(DEPTH);
	localparam int CW  = AW + 1;
	localparam int SW  = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
	localparam int SLW = VALUE_WIDTH + AW + 1;

	// config
	logic [samstk_pkg::NUM_W-1:0]   num_q;
	logic [samstk_pkg::SLOTS_W-1:0] slots_q;
	logic [samstk_pkg::SLOTS_W-1:0] new_slots;
	logic [CW-1:0]                  new_n;

	// free stack bookkeeping; entries below low_q are read as their own index
	logic [CW-1:0]         fc_q;
	logic [CW-1:0]         low_q;
	logic [CW-1:0]         fidx;
	logic [MAX_STACKS-1:0] hv_q;

	// request
	logic                   req_op_q;
	logic [SW-1:0]          req_idx_q;
	logic                   req_range_q;
	logic [VALUE_WIDTH-1:0] req_value_q;

	// result
	logic                                out_valid_q;
	logic [samstk_pkg::DATA_W-1:0]       out_value_q;
	logic [samstk_pkg::STAT_W-1:0]       out_status_q;
	logic [samstk_pkg::STAT_W-1:0]       res_status;
	logic [samstk_pkg::DATA_W-1:0]       res_value;

	// memories
	logic [SW-1:0]  head_raddr;
	logic [AW-1:0]  head_rdata;
	logic           head_we;
	logic [AW-1:0]  head_wdata;
	logic [AW-1:0]  free_rdata;
	logic           free_we;
	logic [SLW-1:0] slot_rdata;
	logic [SLW-1:0] slot_wdata;

	logic           in_range;
	logic [SW-1:0]  in_idx;
	logic           head_valid;
	logic           fc_empty;
	logic           fc_room;
	logic [AW-1:0]  push_slot;
	logic           push_wr;
	logic           pop_wr;
	logic           link_valid;
	logic [AW-1:0]  link_slot;

	assign in_idx   = SW'(s_tuser[samstk_pkg::STKNUM_W:1]);
	assign in_range = (32'(s_tuser[samstk_pkg::STKNUM_W:1]) >= 32'(num_q)) ||
	                  (32'(s_tuser[samstk_pkg::STKNUM_W:1]) >= 32'(MAX_STACKS));

	assign new_slots = (cfg_index == samstk_pkg::REG_SLOTS) ? cfg_data : slots_q;
	assign new_n     = (32'(new_slots) > 32'(DEPTH)) ? CW'(DEPTH) : CW'(new_slots);

	assign head_valid = hv_q[req_idx_q];
	assign fc_empty   = (fc_q == '0);
	assign fc_room    = (fc_q < CW'(DEPTH));
	assign fidx       = fc_q - CW'(1);
	assign push_slot  = (fidx < low_q) ? fidx[AW-1:0] : free_rdata;
	assign link_valid = slot_rdata[SLW-1];
	assign link_slot  = slot_rdata[SLW-2:VALUE_WIDTH];

	assign push_wr = cmd.finish && !cmd.in_fetch && !req_range_q &&
	                 (req_op_q == samstk_pkg::OP_PUSH) && !fc_empty;
	assign pop_wr  = cmd.finish && cmd.in_fetch;

	assign sts.pop_go   = !req_range_q && (req_op_q == samstk_pkg::OP_POP) && head_valid;
	assign sts.out_free = !out_valid_q || m_tready;

	// result code
	always_comb begin
		res_value = '0;
		if (req_range_q) begin
			res_status = samstk_pkg::ST_RANGE;
		end else if (cmd.in_fetch) begin
			res_status = samstk_pkg::ST_DONE;
			res_value  = samstk_pkg::DATA_W'(slot_rdata[VALUE_WIDTH-1:0]);
		end else if (req_op_q == samstk_pkg::OP_POP) begin
			res_status = samstk_pkg::ST_EMPTY;
		end else if (fc_empty) begin
			res_status = samstk_pkg::ST_FULL;
		end else begin
			res_status = samstk_pkg::ST_DONE;
		end
	end

	// config and free-stack control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q   <= samstk_pkg::NUM_STACKS_RST;
			slots_q <= samstk_pkg::SLOTS_IN_USE_RST;
			fc_q    <= (32'(samstk_pkg::SLOTS_IN_USE_RST) > 32'(DEPTH)) ?
			           CW'(DEPTH) : CW'(samstk_pkg::SLOTS_IN_USE_RST);
			low_q   <= (32'(samstk_pkg::SLOTS_IN_USE_RST) > 32'(DEPTH)) ?
			           CW'(DEPTH) : CW'(samstk_pkg::SLOTS_IN_USE_RST);
			hv_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				samstk_pkg::REG_NUM_STACKS: num_q <= cfg_data[samstk_pkg::NUM_W-1:0];
				samstk_pkg::REG_SLOTS:      slots_q <= cfg_data;
				default: ;
			endcase
			fc_q  <= new_n;
			low_q <= new_n;
			hv_q  <= '0;
		end else if (push_wr) begin
			fc_q           <= fidx;
			hv_q[req_idx_q] <= 1'b1;
			if (fidx < low_q) begin
				low_q <= fidx;
			end
		end else if (pop_wr) begin
			hv_q[req_idx_q] <= link_valid;
			if (fc_room) begin
				fc_q <= fc_q + CW'(1);
			end
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_op_q    <= s_tuser[0];
			req_idx_q   <= in_idx;
			req_range_q <= in_range;
			req_value_q <= VALUE_WIDTH'(s_tdata);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_value_q  <= res_value;
			out_status_q <= res_status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = out_status_q;

	// head pointers
	assign head_raddr = cmd.capture ? in_idx : req_idx_q;
	assign head_we    = push_wr || pop_wr;
	assign head_wdata = pop_wr ? link_slot : push_slot;

	samstk_ram #(.WIDTH(AW), .DEPTH(MAX_STACKS)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (req_idx_q),
		.wdata (head_wdata),
		.raddr (head_raddr),
		.rdata (head_rdata)
	);

	// free-slot stack
	assign free_we = pop_wr && fc_room;

	samstk_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_free_ram (
		.clk   (clk),
		.we    (free_we),
		.waddr (fc_q[AW-1:0]),
		.wdata (head_rdata),
		.raddr (fidx[AW-1:0]),
		.rdata (free_rdata)
	);

	// slot store: {link valid, link, value}
	assign slot_wdata = {head_valid, head_rdata, req_value_q};

	samstk_ram #(.WIDTH(SLW), .DEPTH(DEPTH)) u_slot_ram (
		.clk   (clk),
		.we    (push_wr),
		.waddr (push_slot),
		.wdata (slot_wdata),
		.raddr (head_rdata),
		.rdata (slot_rdata)
	);

endmodule

// File: rtl/samstk_chk.sv
// ----------------------------------------------------------------------------
// samstk_chk
// Port-level checks for the shared-array multi-stack, bound to the top level.
// ----------------------------------------------------------------------------
module samstk_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [samstk_pkg::DATA_W-1:0] m_tdata,
	input logic [samstk_pkg::STAT_W-1:0] m_tuser
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// only a successful pop carries a value
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != samstk_pkg::ST_DONE) |-> (m_tdata == '0))
		else $error("nonzero value on a failed request");

	// one request in flight
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while one is in flight");

	// unless an older result is still stalled, no result is valid in the cycle right after an accept
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !(m_tvalid && !m_tready) |=> !m_tvalid)
		else $error("result appeared too early");

endmodule

bind shared_array_multi_stack_top samstk_chk u_samstk_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
